// ----- design/adsr_env_pkg.sv -----
// types, constants and codes shared by the adsr envelope generator files
`timescale 1ns / 1ps
`default_nettype none

package adsr_env_pkg;

  localparam int unsigned GainWidth   = 24;
  localparam int unsigned ModWidth    = 16;
  localparam int unsigned ModFrac     = ModWidth - 2;
  localparam int unsigned StepWidth   = GainWidth + 3;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [GainWidth-1:0] PeakGainReset = GainWidth'(32'h0040_0000);

  // request codes
  localparam logic [1:0] ReqTick    = 2'd0;
  localparam logic [1:0] ReqRetrig  = 2'd1;
  localparam logic [1:0] ReqRelease = 2'd2;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] CfgAttackRate   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgDecayRate    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgReleaseRate  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgPeakGain     = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgSustainLevel = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgHoldSustain  = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CfgModEnable    = 3'd6;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhAttack  = 3'd1,
    PhDecay   = 3'd2,
    PhSustain = 3'd3,
    PhRelease = 3'd4
  } phase_e;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic signed [ModWidth-1:0] mod_value;
  } adsr_env_in_t;

  typedef struct packed {
    logic [GainWidth-1:0] gain_out;
    phase_e               phase_out;
  } adsr_env_out_t;

endpackage

`default_nettype wire

// ----- design/adsr_envelope_generator_core.sv -----
// linear adsr envelope generator, top level
`timescale 1ns / 1ps
`default_nettype none

// Linear ADSR envelope generator. Every input transaction (sample tick, retrigger or release)
// gives exactly one output transaction carrying the envelope gain and phase after it. The block
// takes one transaction per clock cycle while the output is not stalled: an input register, then
// one combinational pass (the two modulation multipliers, attack and decay rate times the
// modulation sample, and the envelope update) into the envelope state register, which is also
// the output register. A stalled output holds while the input register takes one more
// transaction, then the input stalls. Register writes are taken every cycle and should be made
// only while no transaction is in flight.
module adsr_envelope_generator_core (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  adsr_env_pkg::adsr_env_in_t      in_data_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output adsr_env_pkg::adsr_env_out_t           out_data_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [adsr_env_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire  [adsr_env_pkg::GainWidth-1:0]    cfg_data_i
);
  import adsr_env_pkg::*;

  localparam int unsigned ProdWidth = GainWidth + ModWidth + 1;

  // configuration registers
  logic [GainWidth-1:0] attack_rate_q, decay_rate_q, release_rate_q;
  logic [GainWidth-1:0] peak_gain_q, sustain_level_q;
  logic                 hold_sustain_q, mod_enable_q;

  // input register
  logic                        s1_valid_q, out_valid_q;
  logic [1:0]                  s1_req_q;
  logic signed [ModWidth-1:0]  s1_mod_q;
  logic [StepWidth-1:0]        step_a, step_d;

  // envelope state, shown directly on the output
  phase_e               phase_q, phase_d;
  logic [GainWidth-1:0] gain_q, gain_d;

  logic out_free, s1_go, s1_free, in_take, cfg_we;

  logic signed [GainWidth:0]   rate_a_s, rate_d_s;
  logic signed [ProdWidth-1:0] prod_a, prod_d;
  logic signed [ProdWidth-1:0] prod_a_sh, prod_d_sh;

  logic [StepWidth:0]   gain_ext, sum_a, sum_d;
  logic [GainWidth-1:0] sat_a, sat_d, rel_gain;
  logic [GainWidth:0]   rel_diff;

  function automatic logic [GainWidth-1:0] sat_gain(input logic [StepWidth:0] v);
    logic [GainWidth-1:0] r;
    if (v[StepWidth]) begin
      r = '0;
    end else if (|v[StepWidth-1:GainWidth]) begin
      r = '1;
    end else begin
      r = v[GainWidth-1:0];
    end
    return r;
  endfunction

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || s1_go;
  assign in_take    = in_valid_i && s1_free;
  assign in_stall_o = !s1_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = '{gain_out: gain_q, phase_out: phase_q};

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // modulated steps, floor of rate times mod over 2^frac
  assign rate_a_s  = signed'({1'b0, attack_rate_q});
  assign rate_d_s  = signed'({1'b0, decay_rate_q});
  assign prod_a    = rate_a_s * s1_mod_q;
  assign prod_d    = rate_d_s * s1_mod_q;
  assign prod_a_sh = prod_a >>> ModFrac;
  assign prod_d_sh = prod_d >>> ModFrac;

  always_comb begin
    if (mod_enable_q) begin
      step_a = prod_a_sh[StepWidth-1:0];
      step_d = prod_d_sh[StepWidth-1:0];
    end else begin
      step_a = StepWidth'(attack_rate_q);
      step_d = StepWidth'(decay_rate_q);
    end
  end

  // envelope update
  assign gain_ext = (StepWidth+1)'(gain_q);
  assign sum_a    = gain_ext + {step_a[StepWidth-1], step_a};
  assign sum_d    = gain_ext - {step_d[StepWidth-1], step_d};
  assign sat_a    = sat_gain(sum_a);
  assign sat_d    = sat_gain(sum_d);
  assign rel_diff = {1'b0, gain_q} - {1'b0, release_rate_q};
  assign rel_gain = rel_diff[GainWidth] ? '0 : rel_diff[GainWidth-1:0];

  always_comb begin
    phase_d = phase_q;
    gain_d  = gain_q;
    unique case (s1_req_q)
      ReqTick: begin
        unique case (phase_q)
          PhAttack: begin
            if (sat_a >= peak_gain_q) begin
              gain_d  = peak_gain_q;
              phase_d = PhDecay;
            end else begin
              gain_d = sat_a;
            end
          end
          PhDecay: begin
            if (sat_d <= sustain_level_q) begin
              gain_d  = sustain_level_q;
              phase_d = hold_sustain_q ? PhSustain : PhRelease;
            end else begin
              gain_d = sat_d;
            end
          end
          PhSustain: begin
            gain_d = sustain_level_q;
          end
          PhRelease: begin
            gain_d = rel_gain;
            if (rel_gain == '0) begin
              phase_d = PhIdle;
            end
          end
          default: begin
          end
        endcase
      end
      ReqRetrig: begin
        phase_d = PhAttack;
        gain_d  = '0;
      end
      ReqRelease: begin
        if (phase_q != PhIdle) begin
          phase_d = PhRelease;
        end
      end
      default: begin
      end
    endcase
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      phase_q         <= PhIdle;
      gain_q          <= '0;
      attack_rate_q   <= '0;
      decay_rate_q    <= '0;
      release_rate_q  <= '0;
      peak_gain_q     <= PeakGainReset;
      sustain_level_q <= '0;
      hold_sustain_q  <= 1'b1;
      mod_enable_q    <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_go) begin
        phase_q <= phase_d;
        gain_q  <= gain_d;
      end
      if (cfg_we) begin
        unique case (cfg_index_i)
          CfgAttackRate:   attack_rate_q   <= cfg_data_i;
          CfgDecayRate:    decay_rate_q    <= cfg_data_i;
          CfgReleaseRate:  release_rate_q  <= cfg_data_i;
          CfgPeakGain:     peak_gain_q     <= cfg_data_i;
          CfgSustainLevel: sustain_level_q <= cfg_data_i;
          CfgHoldSustain:  hold_sustain_q  <= cfg_data_i[0];
          CfgModEnable:    mod_enable_q    <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q <= in_data_i.req_type;
      s1_mod_q <= in_data_i.mod_value;
    end
  end

endmodule

`default_nettype wire

// ----- design/adsr_env_checker.sv -----
// port-level checks for the adsr envelope generator and their bind
`timescale 1ns / 1ps
`default_nettype none

module adsr_env_port_checks (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               in_stall_o,
  input wire                               out_valid_o,
  input wire                               out_stall_i,
  input wire adsr_env_pkg::adsr_env_out_t  out_data_o
);
  import adsr_env_pkg::*;

  // the input side only backs up when the output side is holding a result
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output is not held");

  // idle is only reached with zero gain
  a_idle_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.phase_out == PhIdle)) |-> (out_data_o.gain_out == '0))
    else $error("idle phase with nonzero gain");

  // a held transaction stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output changed");

endmodule

bind adsr_envelope_generator_core adsr_env_port_checks u_adsr_env_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
